FILE: sv/integer_to_ascii_radix_formatter_top_defines.svh
// Assertion macros shared by the integer to ASCII formatter RTL.
// Include this header in files that check their own sequencing logic.
`ifndef INTEGER_TO_ASCII_RADIX_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_FORMATTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define ITOARF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("itoarf: same-cycle check failed");
`define ITOARF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("itoarf: next-cycle check failed");
`else
`define ITOARF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ITOARF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/itoarf_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and character codes of the integer formatter.
// No dependencies; the channel interfaces and the top module import this package.
package itoarf_pkg;

	localparam int MaxBitsDefault = 32;
	localparam int ValueW = 32;
	localparam int ChunkW = $clog2(ValueW / 4);
	localparam int CharW = 7;
	localparam int RadixW = 5;
	localparam int PadW = 7;
	localparam int WidthCodeW = 2;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 7;

	typedef enum logic [CfgIdxW-1:0] {
		REG_RADIX      = 2'd0,
		REG_PAD_DIGITS = 2'd1,
		REG_WIDTH_CODE = 2'd2,
		REG_IS_SIGNED  = 2'd3
	} cfg_reg_t;

	localparam logic [WidthCodeW-1:0] WidthCode8 = 2'd0;
	localparam logic [WidthCodeW-1:0] WidthCode16 = 2'd1;

	localparam logic [RadixW-1:0] Radix2 = 5'd2;
	localparam logic [RadixW-1:0] Radix8 = 5'd8;
	localparam logic [RadixW-1:0] Radix10 = 5'd10;
	localparam logic [RadixW-1:0] Radix16 = 5'd16;

	localparam logic [CharW-1:0] ChMinus = 7'h2D;
	localparam logic [CharW-1:0] ChZero = 7'h30;
	localparam logic [CharW-1:0] ChLowB = 7'h62;
	localparam logic [CharW-1:0] ChLowO = 7'h6F;
	localparam logic [CharW-1:0] ChLowX = 7'h78;
	localparam logic [CharW-1:0] ChUpA = 7'h41;

	function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
		if (d < 4'd10) begin
			return ChZero + 7'(d);
		end
		return ChUpA + 7'(d) - 7'd10;
	endfunction

endpackage

FILE: sv/itoarf_in_if.sv
`timescale 1ns / 1ps
// Input channel of the integer formatter: one integer value per word.
// Depends on itoarf_pkg.
interface itoarf_in_if import itoarf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ValueW-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

FILE: sv/itoarf_out_if.sv
`timescale 1ns / 1ps
// Output channel of the integer formatter: one ASCII character per word.
// Depends on itoarf_pkg.
interface itoarf_out_if import itoarf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CharW-1:0] character;
	logic             last;
	logic             error;

	modport source(output valid, output character, output last, output error, input ready);
	modport sink(input valid, input character, input last, input error, output ready);
endinterface

FILE: sv/itoarf_cfg_if.sv
`timescale 1ns / 1ps
// Register write channel of the integer formatter: index and data per word.
// Depends on itoarf_pkg.
interface itoarf_cfg_if import itoarf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: sv/integer_to_ascii_radix_formatter_top.sv
`timescale 1ns / 1ps
// Integer to ASCII radix formatter: sequencer, nibble divider and digit memory.
// Depends on itoarf_pkg, the three channel interfaces and the assertion header.
//
// Each accepted value is turned into ASCII text, one character per output word, with last
// set on the final character. The block takes one value at a time and is not ready until
// the previous value has been fully sequenced. Digits come from a shared divider that
// handles four quotient bits per cycle. After that, the sign step is always passed, whether
// or not a minus is sent, prefix and pad characters are sent one at a time, and every digit
// character is read back from the digit memory in a fetch step before it is sent, so a
// fetch step also lies between the padding and the first digit. A zero value skips
// division, and a bad radix gives its single error word from the error state.
// Register writes are accepted at any time but belong between numbers.
`include "integer_to_ascii_radix_formatter_top_defines.svh"

module integer_to_ascii_radix_formatter_top import itoarf_pkg::*; #(
	parameter int MAX_BITS = MaxBitsDefault
) (
	input logic         clk,
	input logic         arst_n,
	itoarf_cfg_if.sink  cfg,
	itoarf_in_if.sink   number,
	itoarf_out_if.source text
);

	localparam int CntW = $clog2(MAX_BITS + 1);
	localparam int AddrW = $clog2(MAX_BITS);
	localparam logic [6:0] MaxBits7 = 7'(MAX_BITS);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DIV   = 9'b000000010,
		S_ERR   = 9'b000000100,
		S_SIGN  = 9'b000001000,
		S_PFX0  = 9'b000010000,
		S_PFX1  = 9'b000100000,
		S_PAD   = 9'b001000000,
		S_FETCH = 9'b010000000,
		S_DIGIT = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	logic [RadixW-1:0]     radix_q;
	logic [PadW-1:0]       pad_cfg_q;
	logic [WidthCodeW-1:0] width_code_q;
	logic                  is_signed_q;

	logic [ValueW-1:0] q_q;
	logic [3:0]        rem_q;
	logic              neg_q;
	logic [5:0]        pad_q;
	logic [ChunkW-1:0] chunk_top_q;
	logic [ChunkW-1:0] chunk_q;
	logic [CntW-1:0]   cnt_q;
	logic [5:0]        zeros_q;
	logic [3:0]        rd_q;
	logic [3:0]        digit_mem [MAX_BITS];

	logic             ovalid_q;
	logic [CharW-1:0] ochar_q;
	logic             olast_q;
	logic             oerr_q;

	logic              accept;
	logic              slot_free;
	logic              radix_ok;
	logic              has_pfx;
	logic [6:0]        w7;
	logic [5:0]        w;
	logic [ValueW-1:0] mask;
	logic [ValueW-1:0] raw;
	logic              neg;
	logic [ValueW-1:0] mag;
	logic signed [7:0] pad_s;
	logic [ChunkW-1:0] chunk_top;
	logic [3:0]        nib;
	logic [3:0]        qnib;
	logic [3:0]        rem_new;
	logic [ValueW-1:0] q_new;
	logic [5:0]        zeros_calc;
	logic [CntW-1:0]   cnt_dec;
	logic              mem_we;
	logic              push;
	logic [CharW-1:0]  push_char;
	logic              push_last;
	logic              push_err;
	logic [CharW-1:0]  pfx_char;

	assign accept = number.valid && number.ready;
	assign number.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign slot_free = !ovalid_q || text.ready;
	assign cnt_dec = cnt_q - CntW'(1);

	always_comb begin
		radix_ok = radix_q inside {[Radix2:Radix16]};
		has_pfx = radix_q inside {Radix2, Radix8, Radix16};
		case (radix_q)
			Radix2: pfx_char = ChLowB;
			Radix8: pfx_char = ChLowO;
			default: pfx_char = ChLowX;
		endcase
	end

	always_comb begin
		w7 = (width_code_q == WidthCode8) ? 7'd8 :
			(width_code_q == WidthCode16) ? 7'd16 : 7'd32;
		if (w7 > MaxBits7) begin
			w7 = MaxBits7;
		end
		w = w7[5:0];
		mask = {ValueW{1'b1}} >> (6'(ValueW) - w);
		raw = number.value & mask;
		neg = is_signed_q && raw[5'(w - 6'd1)];
		mag = neg ? ((~raw + ValueW'(1)) & mask) : raw;
		chunk_top = ChunkW'(((w + 6'd3) >> 2) - 6'd1);
		pad_s = 8'(signed'(pad_cfg_q));
		if (pad_s == -8'sd1) begin
			if (radix_q == Radix2) begin
				pad_s = signed'({2'b00, w});
			end else if (radix_q == Radix16) begin
				pad_s = signed'({4'b0000, w[5:2]});
			end
		end
		if (pad_s < 8'sd1) begin
			pad_s = 8'sd1;
		end
		if (pad_s > signed'({2'b00, w})) begin
			pad_s = signed'({2'b00, w});
		end
	end

	always_comb begin
		logic [4:0] t;
		logic [3:0] r;
		r = rem_q;
		nib = q_q[{chunk_q, 2'b00} +: 4];
		qnib = '0;
		for (int i = 3; i >= 0; i--) begin
			t = {r, nib[i]};
			if (t >= radix_q) begin
				t = t - radix_q;
				qnib[i] = 1'b1;
			end
			r = t[3:0];
		end
		rem_new = r;
		q_new = q_q;
		q_new[{chunk_q, 2'b00} +: 4] = qnib;
	end

	assign zeros_calc = ({1'b0, pad_q} > 7'(cnt_q)) ? 6'({1'b0, pad_q} - 7'(cnt_q)) : 6'd0;

	always_comb begin
		state_d = state_q;
		push = 1'b0;
		push_char = '0;
		push_last = 1'b0;
		push_err = 1'b0;
		mem_we = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = !radix_ok ? S_ERR : ((mag == '0) ? S_SIGN : S_DIV);
				end
			end
			S_DIV: begin
				if (chunk_q == '0) begin
					mem_we = 1'b1;
					if (q_new == '0) begin
						state_d = S_SIGN;
					end
				end
			end
			S_ERR: begin
				if (slot_free) begin
					push = 1'b1;
					push_last = 1'b1;
					push_err = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_SIGN: begin
				if (!neg_q || slot_free) begin
					push = neg_q;
					push_char = ChMinus;
					state_d = has_pfx ? S_PFX0 : S_PAD;
				end
			end
			S_PFX0: begin
				if (slot_free) begin
					push = 1'b1;
					push_char = ChZero;
					state_d = S_PFX1;
				end
			end
			S_PFX1: begin
				if (slot_free) begin
					push = 1'b1;
					push_char = pfx_char;
					state_d = S_PAD;
				end
			end
			S_PAD: begin
				if (zeros_q == '0) begin
					state_d = S_FETCH;
				end else if (slot_free) begin
					push = 1'b1;
					push_char = ChZero;
					push_last = (zeros_q == 6'd1) && (cnt_q == '0);
					state_d = push_last ? S_IDLE : S_PAD;
				end
			end
			S_FETCH: begin
				state_d = S_DIGIT;
			end
			S_DIGIT: begin
				if (slot_free) begin
					push = 1'b1;
					push_char = digit_char(rd_q);
					push_last = (cnt_q == CntW'(1));
					state_d = push_last ? S_IDLE : S_FETCH;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= Radix10;
			pad_cfg_q <= 7'd1;
			width_code_q <= 2'd2;
			is_signed_q <= 1'b1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_RADIX: radix_q <= cfg.data[RadixW-1:0];
				REG_PAD_DIGITS: pad_cfg_q <= cfg.data[PadW-1:0];
				REG_WIDTH_CODE: width_code_q <= cfg.data[WidthCodeW-1:0];
				REG_IS_SIGNED: is_signed_q <= cfg.data[0];
				default: radix_q <= radix_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			chunk_q <= '0;
			zeros_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						chunk_q <= chunk_top;
					end
				end
				S_DIV: begin
					if (chunk_q == '0) begin
						cnt_q <= cnt_q + CntW'(1);
						chunk_q <= chunk_top_q;
					end else begin
						chunk_q <= chunk_q - ChunkW'(1);
					end
				end
				S_SIGN: begin
					zeros_q <= zeros_calc;
				end
				S_PAD: begin
					if (push) begin
						zeros_q <= zeros_q - 6'd1;
					end
				end
				S_DIGIT: begin
					if (push) begin
						cnt_q <= cnt_dec;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			q_q <= mag;
			rem_q <= '0;
			neg_q <= neg;
			pad_q <= pad_s[5:0];
			chunk_top_q <= chunk_top;
		end else if (state_q == S_DIV) begin
			q_q <= q_new;
			rem_q <= (chunk_q == '0) ? 4'd0 : rem_new;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[cnt_q[AddrW-1:0]] <= rem_new;
		end
		rd_q <= digit_mem[cnt_dec[AddrW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (push) begin
			ovalid_q <= 1'b1;
		end else if (text.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ochar_q <= push_char;
			olast_q <= push_last;
			oerr_q <= push_err;
		end
	end

	assign text.valid = ovalid_q;
	assign text.character = ochar_q;
	assign text.last = olast_q;
	assign text.error = oerr_q;

	`ITOARF_ASSERT_IMPLY(a_err_word, clk, arst_n, text.valid && text.error, text.last && (text.character == '0))
	`ITOARF_ASSERT_IMPLY(a_rem_range, clk, arst_n, state_q == S_DIV, 5'(rem_q) < radix_q)
	`ITOARF_ASSERT_IMPLY(a_cnt_bound, clk, arst_n, state_q == S_DIV, 7'(cnt_q) < MaxBits7)
	`ITOARF_ASSERT_NEXT(a_last_idle, clk, arst_n, push && push_last, state_q == S_IDLE)

endmodule
